/* hw/rtl/gps_pkg.sv */
// ----------------------------------------------------------------------------
// gps_pkg
// Shared widths, register codes, item type and decay table function for the
// gaze point smoother.
// ----------------------------------------------------------------------------
package gps_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int COORD_W         = COORD_FRAC_BITS + 1;
  localparam logic [COORD_W-1:0] COORD_ONE = COORD_W'(1) << COORD_FRAC_BITS;
  localparam int TS_W            = 48;
  localparam int CFG_W           = 16;
  localparam int CFG_AW          = 2;
  localparam int IN_FIELDS_W     = 2 * COORD_W + TS_W;
  localparam int IN_TDATA_W      = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W    = 2 * COORD_W;
  localparam int OUT_TDATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int WINDOW_DEF      = 5;
  localparam int MAX_STEP_MS_DEF = 100;
  localparam int QDEPTH          = 2;

  localparam logic [CFG_W-1:0] DEADBAND_RST   = 16'd262;
  localparam logic [CFG_W-1:0] STEP_BASE_RST  = 16'd1180;
  localparam logic [CFG_W-1:0] STEP_SLOPE_RST = 16'd9227;

  localparam logic [63:0] DECAY_Q32 = 64'd4269274647;
  localparam logic [63:0] HALF_Q32  = 64'd2147483648;

  typedef enum logic [CFG_AW-1:0] {
    CFG_DEADBAND   = 2'd0,
    CFG_STEP_BASE  = 2'd1,
    CFG_STEP_SLOPE = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic               present;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [TS_W-1:0]    ts;
  } gps_item_t;

  function automatic logic [31:0] alpha_at(input int k);
    logic [63:0] p;
    p = 64'd1 << 32;
    for (int i = 1; i <= k; i++) begin
      p = (p * DECAY_Q32 + HALF_Q32) >> 32;
    end
    return (k == 0) ? 32'd0 : 32'((64'd1 << 32) - p);
  endfunction

endpackage

/* hw/rtl/gaze_point_smoother.sv */
// ----------------------------------------------------------------------------
// gaze_point_smoother
// Median, slew-limited and exponentially smoothed screen gaze point.
//
//   channel  dir  handshake          payload
//   in_      in   tvalid / tready    tuser: present; tdata: raw_x, raw_y, ts
//   out_     out  tvalid / tready    tuser: out_present; tdata: x, y
//   cfg_     in   we                 addr: register index; wdata: 16 bits
//
// An absent frame goes from idle to output; a present frame with no prior
// point passes the median states only. Otherwise limit, square, compare and
// smoothing follow; an engaged slew limit adds a square root (two bits per
// cycle) and two divisions (setup plus 17 quotient bits, shared divider).
// Synchronous reset clears the ring fill and prior point and resets registers.
// A two-item queue accepts input until full while the back end or the
// output stalls; a stalled result holds the back end in its output state.
// ----------------------------------------------------------------------------
module gaze_point_smoother #(
  parameter int WINDOW      = gps_pkg::WINDOW_DEF,
  parameter int MAX_STEP_MS = gps_pkg::MAX_STEP_MS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [gps_pkg::IN_TDATA_W-1:0]  in_tdata,   // raw_x, raw_y, frame_ms
  input  logic                            in_tuser,   // present
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [gps_pkg::OUT_TDATA_W-1:0] out_tdata,  // screen_x, screen_y
  output logic                            out_tuser,  // out_present
  input  logic                            cfg_we,
  input  logic [gps_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [gps_pkg::CFG_W-1:0]       cfg_wdata
);
  import gps_pkg::*;

  gps_item_t push_item, pop_item;
  logic      push, full, pop_valid, pop;

  gps_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (full),
    .q_push    (push),
    .q_item    (push_item)
  );

  gps_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_item  (pop_item)
  );

  gps_back #(
    .WINDOW      (WINDOW),
    .MAX_STEP_MS (MAX_STEP_MS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (pop_valid),
    .q_pop      (pop),
    .q_item     (pop_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

/* hw/rtl/gps_fifo.sv */
// ----------------------------------------------------------------------------
// gps_fifo
// Short item queue between the front and the back of the smoother.
// ----------------------------------------------------------------------------
module gps_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  gps_pkg::gps_item_t push_item,
  output logic              full,
  output logic              pop_valid,
  input  logic              pop,
  output gps_pkg::gps_item_t pop_item
);
  import gps_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  gps_item_t         mem_r [QDEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full      = (cnt_r == CW'(QDEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* hw/rtl/gps_front.sv */
// ----------------------------------------------------------------------------
// gps_front
// Input side: unpacks a frame, saturates the raw point and queues the item.
// ----------------------------------------------------------------------------
module gps_front (
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [gps_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                           in_tuser,
  input  logic                           q_full,
  output logic                           q_push,
  output gps_pkg::gps_item_t             q_item
);
  import gps_pkg::*;

  logic [COORD_W-1:0] raw_x, raw_y;

  assign raw_x = in_tdata[COORD_W-1:0];
  assign raw_y = in_tdata[2*COORD_W-1:COORD_W];

  assign in_tready      = !q_full;
  assign q_push         = in_tvalid && !q_full;
  assign q_item.present = in_tuser;
  assign q_item.x       = (raw_x > COORD_ONE) ? COORD_ONE : raw_x;
  assign q_item.y       = (raw_y > COORD_ONE) ? COORD_ONE : raw_y;
  assign q_item.ts      = in_tdata[IN_FIELDS_W-1:2*COORD_W];

endmodule

/* hw/rtl/gps_back.sv */
// ----------------------------------------------------------------------------
// gps_back
// Sequencer: ring, median, slew limit with root and divider, smoothing.
// ----------------------------------------------------------------------------
module gps_back #(
  parameter int WINDOW      = gps_pkg::WINDOW_DEF,
  parameter int MAX_STEP_MS = gps_pkg::MAX_STEP_MS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [gps_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [gps_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                            q_valid,
  output logic                            q_pop,
  input  gps_pkg::gps_item_t              q_item,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [gps_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tuser
);
  import gps_pkg::*;

  localparam int FW    = $clog2(WINDOW + 1);
  localparam int SW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int MSW   = $clog2(MAX_STEP_MS + 1);
  localparam int LPW   = MSW + CFG_W;
  localparam int LW    = ((MSW + 9 > CFG_W) ? MSW + 9 : CFG_W) + 1;
  localparam int DW    = 2 * COORD_W + 1;
  localparam int SQW   = (2 * LW > DW) ? 2 * LW : DW;
  localparam int SQTOP = ((DW - 1) % 2 == 0) ? DW - 1 : DW - 2;
  localparam int MVW   = COORD_W + 1;
  localparam int RW    = COORD_W + 2;
  localparam int NW    = COORD_W + LW + 1;
  localparam int DCW   = $clog2(LW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MEDX, S_MEDY, S_LIM, S_LIM2, S_SQY, S_SQL, S_CMP,
    S_SQRT, S_NUM, S_DIV, S_SMUL, S_SADD, S_OUT
  } state_t;

  state_t             state_r;
  logic [CFG_W-1:0]   deadband_r, step_base_r, step_slope_r;
  logic [COORD_W-1:0] ring_x_r [WINDOW];
  logic [COORD_W-1:0] ring_y_r [WINDOW];
  logic [FW-1:0]      fill_r;
  logic [SW-1:0]      wslot_r;
  logic               prior_present_r;
  logic [COORD_W-1:0] prior_x_r, prior_y_r;
  logic [TS_W-1:0]    prior_time_r;
  logic               present_r;
  logic [TS_W-1:0]    ts_r;
  logic [COORD_W-1:0] mx_r, my_r, tx_r, ty_r, res_x_r, res_y_r;
  logic [COORD_W-1:0] adx_r, ady_r;
  logic               upx_r, upy_r, sup_r, axis_r;
  logic [MSW-1:0]     ms_r;
  logic [LPW-1:0]     lprod_r;
  logic [LW-1:0]      limit_r;
  logic [DW-1:0]      sq_r, d2_r;
  logic [2*LW-1:0]    lsq_r;
  logic [2*CFG_W-1:0] dsq_r;
  logic [DW-1:0]      sv_r, sres_r, sbit_r;
  logic [RW-1:0]      rem_r;
  logic [LW-1:0]      nlo_r, q_r;
  logic [DCW-1:0]     dcnt_r;
  logic [COORD_W+31:0] sprod_r;
  logic [31:0]        alpha_r;
  logic [31:0]        alpha_tab [MAX_STEP_MS + 1];
  logic               out_tvalid_r, out_tuser_r;
  logic [COORD_W-1:0] out_x_r, out_y_r;

  for (genvar k = 0; k <= MAX_STEP_MS; k++) begin : g_alpha
    assign alpha_tab[k] = alpha_at(k);
  end

  always_ff @(posedge clk) begin
    alpha_r <= alpha_tab[ms_r];
  end

  // median of the filled slots, one axis per cycle
  logic               med_axis;
  logic [COORD_W-1:0] mv_arr [WINDOW];
  logic [FW-1:0]      rank   [WINDOW];
  logic [FW-1:0]      mid;
  logic [COORD_W-1:0] sel_lo, sel_hi, med;
  logic [COORD_W:0]   med_sum;

  assign med_axis = (state_r == S_MEDY);

  always_comb begin
    mid    = fill_r >> 1;
    sel_lo = '0;
    sel_hi = '0;
    for (int i = 0; i < WINDOW; i++) begin
      mv_arr[i] = med_axis ? ring_y_r[i] : ring_x_r[i];
    end
    for (int i = 0; i < WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if (FW'(j) < fill_r && (mv_arr[j] < mv_arr[i] ||
            (mv_arr[j] == mv_arr[i] && j < i))) begin
          rank[i] = rank[i] + FW'(1);
        end
      end
    end
    for (int i = 0; i < WINDOW; i++) begin
      if (FW'(i) < fill_r && rank[i] == mid) begin
        sel_hi = sel_hi | mv_arr[i];
      end
      if (FW'(i) < fill_r && rank[i] == mid - FW'(1)) begin
        sel_lo = sel_lo | mv_arr[i];
      end
    end
    med_sum = {1'b0, sel_lo} + {1'b0, sel_hi} + (COORD_W + 1)'(1);
    med     = fill_r[0] ? sel_hi : med_sum[COORD_W:1];
  end

  // time step, clamped
  logic [TS_W-1:0] dts;
  logic [MSW-1:0]  ms_calc;

  assign dts     = ts_r - prior_time_r;
  assign ms_calc = (ts_r <= prior_time_r) ? MSW'(1) :
                   (dts > TS_W'(MAX_STEP_MS)) ? MSW'(MAX_STEP_MS) : dts[MSW-1:0];

  // root step
  logic [DW-1:0] s_try, sv_nxt, sres_nxt;

  always_comb begin
    s_try = sres_r + sbit_r;
    if (sv_r >= s_try) begin
      sv_nxt   = sv_r - s_try;
      sres_nxt = (sres_r >> 1) + sbit_r;
    end else begin
      sv_nxt   = sv_r;
      sres_nxt = sres_r >> 1;
    end
  end

  // numerator and divide step
  logic [MVW-1:0]     mv;
  logic [NW-1:0]      num;
  logic [RW-1:0]      rem2, rem_nxt;
  logic               qbit;
  logic [LW-1:0]      q_nxt;
  logic [COORD_W-1:0] prior_sel, targ_sel, div_base, smag, sres, dres;

  assign mv        = sres_r[MVW-1:0];
  assign num       = NW'((axis_r ? ady_r : adx_r) * limit_r) + NW'(mv >> 1);
  assign rem2      = {rem_r[RW-2:0], nlo_r[LW-1]};
  assign qbit      = (rem2 >= RW'(mv));
  assign rem_nxt   = qbit ? rem2 - RW'(mv) : rem2;
  assign q_nxt     = {q_r[LW-2:0], qbit};
  assign div_base  = axis_r ? prior_y_r : prior_x_r;
  assign dres      = (axis_r ? upy_r : upx_r) ? div_base + COORD_W'(q_nxt) :
                                                div_base - COORD_W'(q_nxt);
  assign prior_sel = axis_r ? prior_y_r : prior_x_r;
  assign targ_sel  = axis_r ? ty_r : tx_r;
  assign smag      = (targ_sel >= prior_sel) ? targ_sel - prior_sel :
                                               prior_sel - targ_sel;

  logic [COORD_W+31:0] sprod_rnd;
  assign sprod_rnd = sprod_r + (COORD_W + 32)'(HALF_Q32);
  assign sres      = sup_r ? prior_sel + sprod_rnd[COORD_W+31:32] :
                             prior_sel - sprod_rnd[COORD_W+31:32];

  logic [LPW:0] lprod_rnd;
  assign lprod_rnd = {1'b0, lprod_r} + (LPW + 1)'(128);

  logic out_free;
  assign out_free = !out_tvalid_r || out_tready;
  assign q_pop    = (state_r == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r   <= DEADBAND_RST;
      step_base_r  <= STEP_BASE_RST;
      step_slope_r <= STEP_SLOPE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_DEADBAND:   deadband_r   <= cfg_wdata;
        CFG_STEP_BASE:  step_base_r  <= cfg_wdata;
        CFG_STEP_SLOPE: step_slope_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && q_valid && q_item.present) begin
      ring_x_r[wslot_r] <= q_item.x;
      ring_y_r[wslot_r] <= q_item.y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      fill_r          <= '0;
      wslot_r         <= '0;
      prior_present_r <= 1'b0;
      prior_x_r       <= '0;
      prior_y_r       <= '0;
      prior_time_r    <= '0;
      out_tvalid_r    <= 1'b0;
      out_tuser_r     <= 1'b0;
      axis_r          <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && state_r != S_OUT) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            ts_r      <= q_item.ts;
            present_r <= q_item.present;
            if (q_item.present) begin
              wslot_r <= (wslot_r == SW'(WINDOW - 1)) ? '0 : wslot_r + SW'(1);
              if (fill_r != FW'(WINDOW)) begin
                fill_r <= fill_r + FW'(1);
              end
              state_r <= S_MEDX;
            end else begin
              fill_r  <= '0;
              wslot_r <= '0;
              res_x_r <= '0;
              res_y_r <= '0;
              state_r <= S_OUT;
            end
          end
        end
        S_MEDX: begin
          mx_r    <= med;
          ms_r    <= ms_calc;
          state_r <= S_MEDY;
        end
        S_MEDY: begin
          my_r <= med;
          if (prior_present_r && prior_time_r != '0) begin
            state_r <= S_LIM;
          end else begin
            res_x_r <= mx_r;
            res_y_r <= med;
            state_r <= S_OUT;
          end
        end
        S_LIM: begin
          lprod_r <= LPW'(ms_r * step_slope_r);
          upx_r   <= (mx_r >= prior_x_r);
          upy_r   <= (my_r >= prior_y_r);
          adx_r   <= (mx_r >= prior_x_r) ? mx_r - prior_x_r : prior_x_r - mx_r;
          ady_r   <= (my_r >= prior_y_r) ? my_r - prior_y_r : prior_y_r - my_r;
          state_r <= S_LIM2;
        end
        S_LIM2: begin
          limit_r <= LW'(step_base_r) + LW'(lprod_rnd[LPW:8]);
          sq_r    <= DW'(adx_r * adx_r);
          state_r <= S_SQY;
        end
        S_SQY: begin
          d2_r    <= sq_r + DW'(ady_r * ady_r);
          state_r <= S_SQL;
        end
        S_SQL: begin
          lsq_r   <= limit_r * limit_r;
          dsq_r   <= deadband_r * deadband_r;
          state_r <= S_CMP;
        end
        S_CMP: begin
          axis_r <= 1'b0;
          if (SQW'(d2_r) < SQW'(dsq_r)) begin
            tx_r    <= prior_x_r;
            ty_r    <= prior_y_r;
            state_r <= S_SMUL;
          end else if (SQW'(d2_r) > SQW'(lsq_r)) begin
            sv_r    <= d2_r;
            sres_r  <= '0;
            sbit_r  <= DW'(1) << SQTOP;
            state_r <= S_SQRT;
          end else begin
            tx_r    <= mx_r;
            ty_r    <= my_r;
            state_r <= S_SMUL;
          end
        end
        S_SQRT: begin
          sv_r   <= sv_nxt;
          sres_r <= sres_nxt;
          sbit_r <= sbit_r >> 2;
          if (sbit_r == DW'(1)) begin
            state_r <= S_NUM;
          end
        end
        S_NUM: begin
          rem_r   <= RW'(num[NW-1:LW]);
          nlo_r   <= num[LW-1:0];
          q_r     <= '0;
          dcnt_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r  <= rem_nxt;
          nlo_r  <= nlo_r << 1;
          q_r    <= q_nxt;
          dcnt_r <= dcnt_r + DCW'(1);
          if (dcnt_r == DCW'(LW - 1)) begin
            if (axis_r) begin
              ty_r    <= dres;
              axis_r  <= 1'b0;
              state_r <= S_SMUL;
            end else begin
              tx_r    <= dres;
              axis_r  <= 1'b1;
              state_r <= S_NUM;
            end
          end
        end
        S_SMUL: begin
          sprod_r <= smag * alpha_r;
          sup_r   <= (targ_sel >= prior_sel);
          state_r <= S_SADD;
        end
        S_SADD: begin
          if (axis_r) begin
            res_y_r <= sres;
            axis_r  <= 1'b0;
            state_r <= S_OUT;
          end else begin
            res_x_r <= sres;
            axis_r  <= 1'b1;
            state_r <= S_SMUL;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_tvalid_r    <= 1'b1;
            out_tuser_r     <= present_r;
            out_x_r         <= res_x_r;
            out_y_r         <= res_y_r;
            prior_present_r <= present_r;
            prior_x_r       <= res_x_r;
            prior_y_r       <= res_y_r;
            prior_time_r    <= ts_r;
            state_r         <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = OUT_TDATA_W'({out_y_r, out_x_r});

endmodule

/* hw/rtl/gps_checker.sv */
// ----------------------------------------------------------------------------
// gps_checker
// Port-level checks on the smoother's result channel.
// ----------------------------------------------------------------------------
module gps_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [gps_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser
);
  import gps_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result dropped or changed while stalled");

  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("absent frame gave a nonzero point");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[COORD_W-1:0] <= COORD_ONE &&
                   out_tdata[2*COORD_W-1:COORD_W] <= COORD_ONE)
    else $error("point beyond full scale");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind gaze_point_smoother gps_checker u_gps_checker (.*);
